>>> src/angle_unit_vector_smoother_top_macros.svh
// assertion helpers used by the smoother top
`ifndef ANGLE_UNIT_VECTOR_SMOOTHER_TOP_MACROS_SVH
`define ANGLE_UNIT_VECTOR_SMOOTHER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define AUVS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("auvs assertion failed");
`define AUVS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("auvs assertion failed");
`else
`define AUVS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define AUVS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> src/auvs_pkg.sv
package auvs_pkg;

    localparam int ZW           = 27;
    localparam int RW           = 18;
    localparam int VW           = 32;
    localparam int TABLE_STAGES = 24;
    localparam int DEG          = 65536;

    typedef logic signed [ZW-1:0] t_ang;
    typedef logic signed [RW-1:0] t_rot;
    typedef logic signed [VW-1:0] t_vec;

    typedef struct packed {
        logic valid;
        logic flag;
    } t_ctl;

    // atan(2^-i) in degrees scaled by 2^16
    localparam t_ang ATAN_TABLE [TABLE_STAGES] = '{
        27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945,
        27'sd234379,  27'sd117304,  27'sd58666,  27'sd29335,
        27'sd14668,   27'sd7334,    27'sd3667,   27'sd1833,
        27'sd917,     27'sd458,     27'sd229,    27'sd115,
        27'sd57,      27'sd29,      27'sd14,     27'sd7,
        27'sd4,       27'sd2,       27'sd1,      27'sd0
    };

    localparam t_ang DEG90    = t_ang'(90 * DEG);
    localparam t_ang DEG180   = t_ang'(180 * DEG);
    localparam t_ang DEG270   = t_ang'(270 * DEG);
    localparam t_ang DEG360   = t_ang'(360 * DEG);
    localparam t_rot GAIN_Q15 = 18'sd19898;
    localparam logic [16:0] ALPHA_ONE   = 17'd65536;
    localparam logic [16:0] ALPHA_RESET = 17'd32768;

endpackage

>>> src/angle_unit_vector_smoother_top.sv
// channel   | direction | word
// s stream  | in        | tdata[15:0] target_heading, tdata[31:16] current_heading
// m stream  | out       | tdata[15:0] smoothed_heading
// cfg       | in        | blend_fraction, 17 bits, written when i_cfg_we is high
//
// one heading pair per cycle while the skid stage is empty (o_s_tready high)
// the pipe runs through two rotation cell rows side by side, then one vectoring row
// synchronous active-low reset empties the pipe and sets blend_fraction to 32768
// output register plus a skid stage; the pipe only holds when both are full
`include "angle_unit_vector_smoother_top_macros.svh"
module angle_unit_vector_smoother_top #(
    parameter int CORDIC_STAGES   = 16,
    parameter int ANGLE_FRAC_BITS = 7
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [15:0] target_heading, [31:16] current_heading
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata    // [15:0] smoothed_heading
);
    import auvs_pkg::*;

    localparam int N  = (CORDIC_STAGES > TABLE_STAGES) ? TABLE_STAGES : CORDIC_STAGES;
    localparam int SH = 16 - ANGLE_FRAC_BITS;
    localparam logic [23:0] FULL_H = 24'(360 << ANGLE_FRAC_BITS);
    localparam logic [ZW-1:0] HALF_LSB = ZW'(1 << (SH - 1));

    function automatic logic signed [15:0] f_sat16(input t_rot v);
        if (v > 18'sd32767) begin
            return 16'sh7fff;
        end else if (v < -18'sd32768) begin
            return 16'sh8000;
        end else begin
            return v[15:0];
        end
    endfunction

    logic en;
    logic [16:0] r_alpha;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_RESET;
        end else if (i_cfg_we) begin
            r_alpha <= i_cfg_wdata;
        end
    end

    // heading reduction and quadrant fold
    logic [15:0] hd [2];
    logic [23:0] pr_t [2];
    t_ang pr_z [2];
    logic pr_flip [2];
    logic r_pvalid;
    t_ang r_pz [2];
    logic r_pflip [2];

    assign hd[0] = i_s_tdata[15:0];
    assign hd[1] = i_s_tdata[31:16];

    always_comb begin
        for (int r = 0; r < 2; r++) begin
            pr_t[r] = {8'd0, hd[r]};
            for (int k = 3; k >= 0; k--) begin
                if (pr_t[r] >= (FULL_H << k)) begin
                    pr_t[r] = pr_t[r] - (FULL_H << k);
                end
            end
            pr_z[r] = t_ang'({3'd0, pr_t[r]}) <<< SH;
            pr_flip[r] = 1'b0;
            if (pr_z[r] >= DEG270) begin
                pr_z[r] = pr_z[r] - DEG360;
            end else if (pr_z[r] > DEG90) begin
                pr_z[r] = pr_z[r] - DEG180;
                pr_flip[r] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= 1'b0;
        end else if (en) begin
            r_pvalid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 2; r++) begin
                r_pz[r]    <= pr_z[r];
                r_pflip[r] <= pr_flip[r];
            end
        end
    end

    // rotation rows, target in row 0, current in row 1
    t_ctl w_rc [2][N+1];
    t_rot w_rx [2][N+1];
    t_rot w_ry [2][N+1];
    t_ang w_rz [2][N+1];

    for (genvar r = 0; r < 2; r++) begin : g_row
        assign w_rc[r][0] = '{valid: r_pvalid, flag: r_pflip[r]};
        assign w_rx[r][0] = GAIN_Q15;
        assign w_ry[r][0] = '0;
        assign w_rz[r][0] = r_pz[r];
        for (genvar k = 0; k < N; k++) begin : g_cell
            auvs_rot_cell #(.STAGE(k)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (en),
                .i_ctl   (w_rc[r][k]),
                .i_x     (w_rx[r][k]),
                .i_y     (w_ry[r][k]),
                .i_z     (w_rz[r][k]),
                .o_ctl   (w_rc[r][k+1]),
                .o_x     (w_rx[r][k+1]),
                .o_y     (w_ry[r][k+1]),
                .o_z     (w_rz[r][k+1])
            );
        end
    end

    // unflip and saturate
    logic r_svalid;
    logic signed [15:0] r_sx [2];
    logic signed [15:0] r_sy [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_svalid <= 1'b0;
        end else if (en) begin
            r_svalid <= w_rc[0][N].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 2; r++) begin
                r_sx[r] <= f_sat16(w_rc[r][N].flag ? -w_rx[r][N] : w_rx[r][N]);
                r_sy[r] <= f_sat16(w_rc[r][N].flag ? -w_ry[r][N] : w_ry[r][N]);
            end
        end
    end

    // blend products
    logic [16:0] alpha_eff;
    logic signed [16:0] dfx, dfy;
    logic r_b1valid;
    logic signed [34:0] r_prx, r_pry;
    logic signed [15:0] r_cx, r_cy;

    assign alpha_eff = (r_alpha > ALPHA_ONE) ? ALPHA_ONE : r_alpha;
    assign dfx = 17'(r_sx[0]) - 17'(r_sx[1]);
    assign dfy = 17'(r_sy[0]) - 17'(r_sy[1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1valid <= 1'b0;
        end else if (en) begin
            r_b1valid <= r_svalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prx <= $signed({1'b0, alpha_eff}) * dfx;
            r_pry <= $signed({1'b0, alpha_eff}) * dfy;
            r_cx  <= r_sx[1];
            r_cy  <= r_sy[1];
        end
    end

    // round and add back to the current vector
    logic signed [34:0] rnx, rny;
    logic r_b2valid;
    t_rot r_nx, r_ny;

    assign rnx = (r_prx + 35'sd32768) >>> 16;
    assign rny = (r_pry + 35'sd32768) >>> 16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b2valid <= 1'b0;
        end else if (en) begin
            r_b2valid <= r_b1valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nx <= t_rot'(r_cx) + rnx[RW-1:0];
            r_ny <= t_rot'(r_cy) + rny[RW-1:0];
        end
    end

    // vectoring entry: mirror left half-plane, scale by 2^14
    logic r_v0valid, r_v0zero;
    t_vec r_v0x, r_v0y;
    t_ang r_v0z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0valid <= 1'b0;
        end else if (en) begin
            r_v0valid <= r_b2valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_v0zero <= (r_nx == '0) && (r_ny == '0);
            if (r_nx < 0) begin
                r_v0x <= t_vec'(-r_nx) <<< 14;
                r_v0y <= t_vec'(-r_ny) <<< 14;
                r_v0z <= DEG180;
            end else begin
                r_v0x <= t_vec'(r_nx) <<< 14;
                r_v0y <= t_vec'(r_ny) <<< 14;
                r_v0z <= '0;
            end
        end
    end

    t_ctl w_vc [N+1];
    t_vec w_vx [N+1];
    t_vec w_vy [N+1];
    t_ang w_vz [N+1];

    assign w_vc[0] = '{valid: r_v0valid, flag: r_v0zero};
    assign w_vx[0] = r_v0x;
    assign w_vy[0] = r_v0y;
    assign w_vz[0] = r_v0z;

    for (genvar k = 0; k < N; k++) begin : g_vec
        auvs_vec_cell #(.STAGE(k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (w_vc[k]),
            .i_x     (w_vx[k]),
            .i_y     (w_vy[k]),
            .i_z     (w_vz[k]),
            .o_ctl   (w_vc[k+1]),
            .o_x     (w_vx[k+1]),
            .o_y     (w_vy[k+1]),
            .o_z     (w_vz[k+1])
        );
    end

    // wrap into one turn
    logic r_wvalid, r_wzero;
    t_ang r_wz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvalid <= 1'b0;
        end else if (en) begin
            r_wvalid <= w_vc[N].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wzero <= w_vc[N].flag;
            if (w_vz[N] < 0) begin
                r_wz <= w_vz[N] + DEG360;
            end else if (w_vz[N] >= DEG360) begin
                r_wz <= w_vz[N] - DEG360;
            end else begin
                r_wz <= w_vz[N];
            end
        end
    end

    // round to heading units
    logic [ZW-1:0] rsum, rq;
    logic [15:0] push_data;
    logic push;

    always_comb begin
        rsum = (ZW'(r_wz) + HALF_LSB) >> SH;
        rq   = rsum;
        if (rsum >= ZW'(FULL_H)) begin
            rq = rsum - ZW'(FULL_H);
        end
        push_data = r_wzero ? 16'd0 : rq[15:0];
    end

    // output register with skid stage
    logic r_out_valid, r_skid_valid;
    logic [15:0] r_out_data, r_skid_data;
    logic pop;

    assign en   = !r_skid_valid;
    assign push = en && r_wvalid;
    assign pop  = r_out_valid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || pop) begin
            r_out_valid  <= r_skid_valid || push;
            r_skid_valid <= 1'b0;
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            r_out_data <= r_skid_valid ? r_skid_data : push_data;
        end else if (push) begin
            r_skid_data <= push_data;
        end
    end

    assign o_s_tready = en;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    `AUVS_ASSERT_IMP(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `AUVS_ASSERT_NXT(a_out_held, i_clk, i_rst_n, r_out_valid && !i_m_tready, r_out_valid && $stable(r_out_data))
    `AUVS_ASSERT_IMP(a_wrap_range, i_clk, i_rst_n, r_wvalid, (r_wz >= 0) && (r_wz < DEG360))

endmodule

>>> src/auvs_rot_cell.sv
module auvs_rot_cell #(
    parameter int STAGE = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  auvs_pkg::t_ctl  i_ctl,
    input  auvs_pkg::t_rot  i_x,
    input  auvs_pkg::t_rot  i_y,
    input  auvs_pkg::t_ang  i_z,
    output auvs_pkg::t_ctl  o_ctl,
    output auvs_pkg::t_rot  o_x,
    output auvs_pkg::t_rot  o_y,
    output auvs_pkg::t_ang  o_z
);
    import auvs_pkg::*;

    t_ctl r_ctl;
    t_rot r_x, r_y, n_x, n_y;
    t_ang r_z, n_z;
    t_rot dx, dy;

    always_comb begin
        dx = i_y >>> STAGE;
        dy = i_x >>> STAGE;
        if (i_z >= 0) begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_z = i_z - ATAN_TABLE[STAGE];
        end else begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_z = i_z + ATAN_TABLE[STAGE];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

endmodule

>>> src/auvs_vec_cell.sv
module auvs_vec_cell #(
    parameter int STAGE = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  auvs_pkg::t_ctl  i_ctl,
    input  auvs_pkg::t_vec  i_x,
    input  auvs_pkg::t_vec  i_y,
    input  auvs_pkg::t_ang  i_z,
    output auvs_pkg::t_ctl  o_ctl,
    output auvs_pkg::t_vec  o_x,
    output auvs_pkg::t_vec  o_y,
    output auvs_pkg::t_ang  o_z
);
    import auvs_pkg::*;

    t_ctl r_ctl;
    t_vec r_x, r_y, n_x, n_y;
    t_ang r_z, n_z;
    t_vec dx, dy;

    // drive y towards zero, accumulating the angle
    always_comb begin
        dx = i_y >>> STAGE;
        dy = i_x >>> STAGE;
        if (i_y > 0) begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_z = i_z + ATAN_TABLE[STAGE];
        end else begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_z = i_z - ATAN_TABLE[STAGE];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

endmodule

>>> verif/angle_unit_vector_smoother_top_tb.sv
module angle_unit_vector_smoother_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import auvs_pkg::*;

    localparam int STAGES    = 16;
    localparam int FRAC      = 7;
    localparam int FULL_TURN = 360 << FRAC;
    localparam int LATENCY   = 2 * STAGES + 7;
    localparam int CFG_BLEND = 0;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [16:0] i_cfg_wdata = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;    // [15:0] target_heading, [31:16] current_heading
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;         // [15:0] smoothed_heading

    angle_unit_vector_smoother_top u_top (.*);

    always #4 i_clk = ~i_clk;

    logic [31:0] pending_words[$];
    logic [15:0] expected_headings[$];
    logic [16:0] blend_frac = ALPHA_RESET;
    int          fail_count = 0;
    bit          hold_sender = 1'b0;
    int          gap_left = 0;
    int          burst_left = 0;
    int          stall_phase = 0;

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic void heading_to_vector(input logic [15:0] hd,
                                              output longint cx, output longint sy);
        longint z, x, y, dx, dy;
        bit flip;
        z = (longint'(hd) % FULL_TURN) << (16 - FRAC);
        x = GAIN_Q15;
        y = 0;
        flip = 0;
        if (z >= 270 * DEG) z -= 360 * DEG;
        else if (z > 90 * DEG) begin
            z -= 180 * DEG;
            flip = 1;
        end
        for (int i = 0; i < STAGES; i++) begin
            dx = asr(y, i);
            dy = asr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_TABLE[i];
            end else begin
                x += dx; y -= dy; z += ATAN_TABLE[i];
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        cx = x > 32767 ? 32767 : (x < -32768 ? -32768 : x);
        sy = y > 32767 ? 32767 : (y < -32768 ? -32768 : y);
    endfunction

    function automatic longint lerp(longint cur, longint tgt, longint alpha);
        return cur + asr(alpha * (tgt - cur) + 32768, 16);
    endfunction

    function automatic logic [15:0] smoothed_angle(logic [31:0] word);
        longint tx, ty, cx, cy, x, y, z, dx, dy, alpha, r;
        alpha = blend_frac > ALPHA_ONE ? 65536 : blend_frac;
        heading_to_vector(word[15:0], tx, ty);
        heading_to_vector(word[31:16], cx, cy);
        x = lerp(cx, tx, alpha);
        y = lerp(cy, ty, alpha);
        if (x == 0 && y == 0) return '0;
        z = 0;
        if (x < 0) begin
            x = -x; y = -y; z = 180 * DEG;
        end
        // 32-bit wrap of the scaled components
        x = longint'(int'(x * 16384));
        y = longint'(int'(y * 16384));
        for (int i = 0; i < STAGES; i++) begin
            dx = asr(y, i);
            dy = asr(x, i);
            if (y > 0) begin
                x += dx; y -= dy; z += ATAN_TABLE[i];
            end else begin
                x -= dx; y += dy; z -= ATAN_TABLE[i];
            end
            x = longint'(int'(x));
            y = longint'(int'(y));
        end
        if (z < 0) z += 360 * DEG;
        if (z >= 360 * DEG) z -= 360 * DEG;
        r = (z + (1 << (15 - FRAC))) >> (16 - FRAC);
        if (r >= FULL_TURN) r -= FULL_TURN;
        return r[15:0];
    endfunction

    function automatic logic [31:0] pair(int tgt, int cur);
        return {cur[15:0], tgt[15:0]};
    endfunction

    function automatic int rand_heading();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 65535);
            1: return $urandom_range(0, 3) * (FULL_TURN / 4) + $urandom_range(0, 2) - 1 & 16'hffff;
            default: return $urandom_range(0, FULL_TURN - 1);
        endcase
    endfunction

    // driver: bursts with random gaps
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) void'(pending_words.pop_front());
            if (i_s_tvalid && !o_s_tready) begin
            end else if (hold_sender || pending_words.size() == 0 ||
                         (i_s_tvalid && o_s_tready && pending_words.size() == 0)) begin
                i_s_tvalid <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left   <= gap_left - 1;
                i_s_tvalid <= 1'b0;
            end else begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= pending_words[0];
                if (burst_left <= 0) begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
                end else burst_left <= burst_left - 1;
            end
        end
    end

    // receiver stalls on a rotating pattern
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        case ((stall_phase / 200) % 3)
            0: i_m_tready <= 1'b1;
            1: i_m_tready <= ($urandom_range(0, 3) != 0);
            default: i_m_tready <= (stall_phase % 7) > 2;
        endcase
    end

    // monitor
    always @(posedge i_clk) begin
        logic [15:0] want;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                expected_headings.push_back(smoothed_angle(i_s_tdata));
            if (o_m_tvalid && i_m_tready) begin
                if (expected_headings.size() == 0) begin
                    $error("unexpected word smoothed_heading %0d", o_m_tdata);
                    fail_count++;
                end else begin
                    want = expected_headings.pop_front();
                    if (o_m_tdata !== want) begin
                        $error("smoothed_heading expected %0d actual %0d", want, o_m_tdata);
                        fail_count++;
                    end
                end
            end
        end
    end

    task automatic drain();
        wait (pending_words.size() == 0 && !i_s_tvalid);
        wait (expected_headings.size() == 0);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic set_blend(logic [16:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        blend_frac = v;
    endtask

    initial begin
        logic [16:0] settings[6];
        settings = '{17'd0, 17'd65536, 17'h1ffff, 17'd1, 17'd65535, 17'd21845};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed at reset fraction: extremes, opposites, out-of-range headings
        pending_words.push_back(pair(0, 0));
        pending_words.push_back(pair(FULL_TURN - 1, 0));
        pending_words.push_back(pair(0, FULL_TURN / 2));           // opposite, zero length
        pending_words.push_back(pair(FULL_TURN / 4, 3 * FULL_TURN / 4));
        pending_words.push_back(pair(65535, 65535));
        pending_words.push_back(pair(FULL_TURN, FULL_TURN + 1));
        pending_words.push_back(pair(FULL_TURN / 4, FULL_TURN / 4 + 1));
        pending_words.push_back(pair(3 * FULL_TURN / 4, 3 * FULL_TURN / 4 - 1));
        pending_words.push_back(pair(16'haaaa, 16'h5555));
        pending_words.push_back(pair(16'h5555, 16'haaaa));
        pending_words.push_back(pair(FULL_TURN / 2, FULL_TURN / 2 + 1));
        drain();

        for (int k = 0; k < 7; k++) begin
            if (k < 6) set_blend(settings[k]);
            else set_blend(17'(CFG_BLEND + $urandom_range(0, 65536)));
            pending_words.push_back(pair(0, FULL_TURN / 2));
            pending_words.push_back(pair(FULL_TURN - 1, 1));
            for (int n = 0; n < 90; n++) begin
                if (n == 45) begin
                    hold_sender = 1'b1;
                    wait (pending_words.size() == 0 || !i_s_tvalid);
                    wait (expected_headings.size() == 0);
                    hold_sender = 1'b0;
                end
                pending_words.push_back(pair(rand_heading(), rand_heading()));
            end
            drain();
        end
        if (fail_count == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #2ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
